FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle consequence checked at every edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle consequence checked at every edge, reset included.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hw/rtl/fhp_pkg.sv
// Package for the fragment header parser: constants, codes and beat types.
// No dependencies.
package fhp_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [7:0] SEP_CHAR   = 8'h3A;
    localparam logic [7:0] DIGIT0     = 8'h30;
    localparam logic [7:0] DIGIT9     = 8'h39;

    localparam logic [2:0] PH_TOTAL = 3'd0;
    localparam logic [2:0] PH_FRAG  = 3'd1;
    localparam logic [2:0] PH_SIZE  = 3'd2;
    localparam logic [2:0] PH_NAME  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_NAME    = 2'd1;
    localparam logic [1:0] KIND_CONTENT = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        count_t     total_count;
        count_t     fragment_index;
        count_t     content_length;
        logic       starts_file;
        logic       packet_end;
        logic       file_done;
        logic       format_error;
    } out_item_t;

endpackage

FILE: hw/rtl/fhp_in_stage.sv
// Input register stage of the fragment header parser.
// Depends on fhp_pkg.
module fhp_in_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fhp_pkg::in_item_t s_item,
    input  logic             advance,
    output logic             hold_valid,
    output fhp_pkg::in_item_t hold_item
);
    import fhp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    in_item_t item_next;
    logic     take;

    // Take a new beat when the slot is empty or drains this cycle.
    assign s_ready = !valid_reg || advance;
    assign take    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (take) begin
            valid_next = 1'b1;
            item_next  = s_item;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;
endmodule

FILE: hw/rtl/fhp_parse_core.sv
// Parse state and per-byte decode of the fragment header parser.
// Depends on fhp_pkg.
module fhp_parse_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  fhp_pkg::in_item_t  item,
    input  logic               advance,
    output fhp_pkg::out_item_t result
);
    import fhp_pkg::*;

    logic [2:0] phase_reg, phase_next;
    count_t     total_reg, total_next;
    count_t     index_reg, index_next;
    count_t     size_reg,  size_next;
    count_t     left_reg,  left_next;

    logic [2:0] ph_cur;
    count_t     tot_cur, idx_cur, siz_cur, left_cur;
    logic [7:0] b;
    logic [7:0] diff;
    logic       is_sep, is_digit;
    count_t     acc_sel, acc_new, left_dec;
    logic [COUNT_WIDTH+3:0] prod;
    logic [1:0] kind;
    logic       pend, ferr;

    // Multiply by ten as two shifts, add the digit, clamp.
    always_comb begin
        prod = ({4'b0000, acc_sel} << 3) + ({4'b0000, acc_sel} << 1)
             + {{COUNT_WIDTH{1'b0}}, diff[3:0]};
        if (prod > {4'b0000, COUNT_MAX}) begin
            acc_new = COUNT_MAX;
        end else begin
            acc_new = prod[COUNT_WIDTH-1:0];
        end
    end

    always_comb begin
        b        = item.byte_value;
        diff     = b - DIGIT0;
        is_sep   = (b == SEP_CHAR);
        is_digit = (b >= DIGIT0) && (b <= DIGIT9);

        // A first byte restarts the parse before it is decoded.
        ph_cur   = item.first_byte ? PH_TOTAL : phase_reg;
        tot_cur  = item.first_byte ? '0 : total_reg;
        idx_cur  = item.first_byte ? '0 : index_reg;
        siz_cur  = item.first_byte ? '0 : size_reg;
        left_cur = item.first_byte ? '0 : left_reg;

        case (ph_cur)
            PH_TOTAL: acc_sel = tot_cur;
            PH_FRAG:  acc_sel = idx_cur;
            default:  acc_sel = siz_cur;
        endcase
        left_dec = left_cur - count_t'(1);

        phase_next = ph_cur;
        total_next = tot_cur;
        index_next = idx_cur;
        size_next  = siz_cur;
        left_next  = left_cur;
        kind       = KIND_HEADER;
        pend       = 1'b0;
        ferr       = 1'b0;

        case (ph_cur)
            PH_TOTAL, PH_FRAG, PH_SIZE: begin
                if (is_sep) begin
                    phase_next = ph_cur + 3'd1;
                end else if (is_digit) begin
                    if (ph_cur == PH_TOTAL) begin
                        total_next = acc_new;
                    end else if (ph_cur == PH_FRAG) begin
                        index_next = acc_new;
                    end else begin
                        size_next = acc_new;
                    end
                end else begin
                    ferr = 1'b1;
                end
            end
            PH_NAME: begin
                if (is_sep) begin
                    if (siz_cur == '0) begin
                        pend       = 1'b1;
                        phase_next = PH_DONE;
                    end else begin
                        left_next  = siz_cur;
                        phase_next = PH_DATA;
                    end
                end else begin
                    kind = KIND_NAME;
                end
            end
            PH_DATA: begin
                kind      = KIND_CONTENT;
                left_next = left_dec;
                if (left_dec == '0) begin
                    pend       = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            default: begin
                kind = KIND_IGNORED;
            end
        endcase

        result.kind           = kind;
        result.data_byte      = b;
        result.total_count    = total_next;
        result.fragment_index = index_next;
        result.content_length = size_next;
        result.starts_file    = (phase_next >= PH_DATA) && (index_next == count_t'(1));
        result.packet_end     = pend;
        result.file_done      = pend && (index_next == total_next);
        result.format_error   = ferr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TOTAL;
            total_reg <= '0;
            index_reg <= '0;
            size_reg  <= '0;
            left_reg  <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            total_reg <= total_next;
            index_reg <= index_next;
            size_reg  <= size_next;
            left_reg  <= left_next;
        end
    end
endmodule

FILE: hw/rtl/fragment_header_parser.sv
// Top level of the fragment header parser: input stage, parse core, result register.
// Depends on fhp_pkg, fhp_in_stage and fhp_parse_core.
//
//   channel   direction  payload      handshake
//   s_        in         in_item_t    s_valid / s_ready
//   m_        out        out_item_t   m_valid / m_ready
//
// One byte in, one result beat out, one beat per cycle sustained while m_ready stays high.
// The beat passes the input register, then the result register; the
// decode between them is one pass of short logic over the parse state.
// Reset (aresetn low at a clock edge) empties both registers and returns the
// parse to the total-count field with all counters at zero.
// A stall on m_ready holds the result; the input register still takes a beat only
// if it is empty, then s_ready drops until the result drains.
module fragment_header_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fhp_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output fhp_pkg::out_item_t m_item
);
    import fhp_pkg::*;

    logic      hold_valid;
    in_item_t  hold_item;
    logic      advance;
    out_item_t result;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg,  m_item_next;

    // Advance the held byte when the result register is free or drains now.
    assign advance = hold_valid && (!m_valid_reg || m_ready);

    fhp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    // Parse state updates only on the cycle the byte advances.
    fhp_parse_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (hold_item),
        .advance (advance),
        .result  (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (advance) begin
            m_valid_next = 1'b1;
            m_item_next  = result;
        end else if (m_ready) begin
            // drop the beat once taken
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;
endmodule

FILE: hw/rtl/fhp_checker.sv
// Port-level checks for the fragment header parser, bound to the top level.
// Depends on fhp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fhp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input fhp_pkg::out_item_t m_item
);
    import fhp_pkg::*;

    `ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)
    `ASSERT_IMPLIES(a_done_ends, aclk, aresetn, m_valid && m_item.file_done, m_item.packet_end)
    `ASSERT_IMPLIES(a_err_header, aclk, aresetn, m_valid && m_item.format_error, m_item.kind == KIND_HEADER)
    `ASSERT_IMPLIES(a_end_kind, aclk, aresetn, m_valid && m_item.packet_end, m_item.kind == KIND_HEADER || m_item.kind == KIND_CONTENT)
endmodule

bind fragment_header_parser fhp_checker u_fhp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

FILE: bench/tb_fragment_header_parser.sv
// Testbench for fragment_header_parser: sends datagram bytes through the valid/ready
// input channel and checks every result beat against a behavioral predictor.
// Depends on fhp_pkg and the fragment_header_parser RTL.
`timescale 1ns / 1ps

module tb_fragment_header_parser;
    import fhp_pkg::*;

    localparam int DEC_RADIX     = 10;
    localparam int IDLE_PERCENT  = 13;
    localparam int DRAIN_CYCLES  = 10;
    localparam int PRINT_LIMIT   = 40;
    localparam int STEADY_BEATS  = 200;
    localparam int PARSED_TARGET = 1700;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // Predictor state: what the parser should hold after each accepted byte.
    logic [2:0] parse_phase;
    count_t     total_seen;
    count_t     index_seen;
    count_t     size_seen;
    count_t     content_left;

    out_item_t  expected_results[$];
    logic [7:0] frame_bytes[$];
    int         error_count;
    int         result_beats;
    int         parsed_beats;   // beats whose expected kind is not "ignored"
    bit         steady_flow;    // when set, neither side idles

    fragment_header_parser DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Fold one decimal digit into a counter, pinning it at the top value.
    function automatic count_t add_digit(count_t acc, logic [7:0] ch);
        logic [63:0] wide;
        wide = 64'(acc) * DEC_RADIX + 64'(ch - DIGIT0);
        return (wide > 64'(COUNT_MAX)) ? COUNT_MAX : wide[COUNT_WIDTH-1:0];
    endfunction

    // Advance the predicted parse by one byte and return the beat it must produce.
    function automatic out_item_t parse_byte(in_item_t it);
        out_item_t  r;
        logic [7:0] b;
        b = it.byte_value;
        r = '0;
        r.data_byte = b;
        // A first byte restarts the parse before it is itself parsed.
        if (it.first_byte) begin
            parse_phase  = PH_TOTAL;
            total_seen   = '0;
            index_seen   = '0;
            size_seen    = '0;
            content_left = '0;
        end
        if (parse_phase <= PH_SIZE) begin
            r.kind = KIND_HEADER;
            if (b == SEP_CHAR) begin
                parse_phase = parse_phase + 3'd1;
            end else if (b >= DIGIT0 && b <= DIGIT9) begin
                case (parse_phase)
                    PH_TOTAL: total_seen = add_digit(total_seen, b);
                    PH_FRAG:  index_seen = add_digit(index_seen, b);
                    default:  size_seen  = add_digit(size_seen, b);
                endcase
            end else begin
                // Bad digit: flag it for this byte only, leave the counter alone.
                r.format_error = 1'b1;
            end
        end else if (parse_phase == PH_NAME) begin
            if (b == SEP_CHAR) begin
                // Fourth colon: with an empty content the packet ends right here.
                if (size_seen == '0) begin
                    r.packet_end = 1'b1;
                    parse_phase  = PH_DONE;
                end else begin
                    content_left = size_seen;
                    parse_phase  = PH_DATA;
                end
            end else begin
                r.kind = KIND_NAME;
            end
        end else if (parse_phase == PH_DATA) begin
            r.kind = KIND_CONTENT;
            content_left = content_left - count_t'(1);
            if (content_left == '0) begin
                r.packet_end = 1'b1;
                parse_phase  = PH_DONE;
            end
        end else begin
            r.kind = KIND_IGNORED;
        end
        r.file_done      = r.packet_end && (index_seen == total_seen);
        r.total_count    = total_seen;
        r.fragment_index = index_seen;
        r.content_length = size_seen;
        r.starts_file    = (parse_phase >= PH_DATA) && (index_seen == count_t'(1));
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("ERROR result beat %0d, %s: got 0x%0h, want 0x%0h",
                     result_beats, what, got, want);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // Drive one byte from a falling edge and hold it until the parser takes it.
    // Return at the next falling edge with valid still high, so a following
    // byte can go out back to back.
    task automatic send_byte(logic [7:0] value, bit mark_first);
        in_item_t  it;
        out_item_t predicted;
        it.byte_value = value;
        it.first_byte = mark_first;
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = parse_byte(it);
        expected_results.push_back(predicted);
        if (predicted.kind != KIND_IGNORED)
            parsed_beats++;
        @(negedge aclk);
    endtask

    task automatic send_text(string txt, bit mark_first);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], mark_first && (i == 0));
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == 0);
    endtask

    // Append a decimal field and its colon, now and then with a leading zero.
    function automatic void push_field(longint unsigned v);
        string digits;
        digits = $sformatf("%0d", v);
        if ($urandom_range(9) == 0)
            frame_bytes.push_back(DIGIT0);
        for (int i = 0; i < digits.len(); i++)
            frame_bytes.push_back(digits[i]);
        frame_bytes.push_back(SEP_CHAR);
    endfunction

    // Mostly small counts, with some full-range and some far past saturation.
    function automatic longint unsigned pick_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)      return 64'($urandom_range(9));
        else if (roll < 85) return 64'($urandom_range(300, 10));
        else if (roll < 95) return 64'($urandom_range(65535));
        else                return 64'($urandom_range(9999999, 65536));
    endfunction

    // Build one datagram with random content, break some of them, and send it.
    task automatic send_random_datagram();
        longint unsigned total_v;
        longint unsigned index_v;
        int unsigned     size_v;
        int unsigned     roll;
        logic [7:0]      b;
        frame_bytes.delete();
        total_v = pick_count();
        roll = $urandom_range(2);
        index_v = (roll == 0) ? total_v : (roll == 1) ? 1 : pick_count();
        size_v = ($urandom_range(19) == 0) ? $urandom_range(40, 9) : $urandom_range(8);
        push_field(total_v);
        push_field(index_v);
        push_field(size_v);
        repeat ($urandom_range(5)) begin
            do b = 8'($urandom_range(255)); while (b == SEP_CHAR);
            frame_bytes.push_back(b);
        end
        frame_bytes.push_back(SEP_CHAR);
        repeat (size_v) frame_bytes.push_back(8'($urandom_range(255)));
        repeat ($urandom_range(2)) frame_bytes.push_back(8'($urandom_range(255)));

        roll = $urandom_range(99);
        if (roll < 5) begin
            // Corrupt one byte anywhere in the datagram.
            frame_bytes[$urandom_range(frame_bytes.size() - 1)] = 8'($urandom_range(255));
        end else if (roll < 9) begin
            // Cut the datagram short; the next one restarts the parse.
            frame_bytes = frame_bytes[0:$urandom_range(frame_bytes.size() - 1)];
        end else if (roll < 12) begin
            // Drop the start marker: the bytes run on in the current phase.
            for (int i = 0; i < frame_bytes.size(); i++)
                send_byte(frame_bytes[i], 1'b0);
            return;
        end
        send_frame();
    endtask

    // Right after reset, parsing must start in the total field without a marker.
    // Empty content ends the packet on the fourth colon; the byte after is ignored.
    task automatic test_parse_after_reset();
        send_text("1:1:0:n:", 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // Bytes just below the digits and just above the colon are bad digits;
    // an empty name and a single zero content byte follow.
    task automatic test_bad_digits_and_empty_name();
        send_text("9/;:2:1::", 1'b1);
        send_byte(8'h00, 1'b0);
    endtask

    // Push the total count past the counter range.
    task automatic test_count_saturation();
        send_text("99999:", 1'b1);
    endtask

    // Back-to-back datagrams with neither side idling.
    task automatic test_steady_stream();
        int stop_at;
        stop_at = parsed_beats + STEADY_BEATS;
        steady_flow = 1'b1;
        while (parsed_beats < stop_at)
            send_random_datagram();
        steady_flow = 1'b0;
    endtask

    task automatic test_random_datagrams();
        while (parsed_beats < PARSED_TARGET)
            send_random_datagram();
    endtask

    // Result side: stall at random, except during the steady stretch.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Compare each result beat with the oldest prediction.
    initial begin : result_checker
        out_item_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                result_beats++;
                if (expected_results.size() == 0) begin
                    report_mismatch("beat with nothing expected", 32'(m_item.data_byte), 0);
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 32'(m_item.kind), 32'(want.kind));
                    check_field("data_byte", 32'(m_item.data_byte), 32'(want.data_byte));
                    check_field("total_count", 32'(m_item.total_count),
                                32'(want.total_count));
                    check_field("fragment_index", 32'(m_item.fragment_index),
                                32'(want.fragment_index));
                    check_field("content_length", 32'(m_item.content_length),
                                32'(want.content_length));
                    check_field("starts_file", 32'(m_item.starts_file),
                                32'(want.starts_file));
                    check_field("packet_end", 32'(m_item.packet_end),
                                32'(want.packet_end));
                    check_field("file_done", 32'(m_item.file_done), 32'(want.file_done));
                    check_field("format_error", 32'(m_item.format_error),
                                32'(want.format_error));
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_fragment_header_parser NOT OK");
        $finish;
    end

    initial begin
        error_count  = 0;
        result_beats = 0;
        parsed_beats = 0;
        steady_flow  = 1'b0;
        parse_phase  = PH_TOTAL;
        total_seen   = '0;
        index_seen   = '0;
        size_seen    = '0;
        content_left = '0;
        s_valid = 1'b0;
        s_item  = '0;
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_parse_after_reset();
        test_bad_digits_and_empty_name();
        test_count_saturation();
        test_steady_stream();
        test_random_datagrams();
        s_valid <= 1'b0;

        // Drain, then keep watching for stray beats.
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch("results never arrived", expected_results.size(), 0);

        if (error_count == 0)
            $display("tb_fragment_header_parser OK");
        else
            $display("tb_fragment_header_parser NOT OK");
        $finish;
    end

endmodule
